// File: sv/hlst_pkg.sv
// ----------------------------------------------------------------------------
// hlst_pkg: shared types and constants for the hashed label slot table
// Channel layouts, hash shift amounts, command codes and the command/status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package hlst_pkg;

   localparam int HashBits    = 32;
   localparam int KeyCharBits = 7;
   localparam int ValueBits   = 16;
   localparam int KindBits    = 2;
   localparam int CharsBits   = 6;

   // stream payload widths, padded to whole bytes
   localparam int ReqDataBits = 24;
   localparam int RspDataBits = 24;

   // one-at-a-time mixing and finalization shifts
   localparam int MixShiftA = 10;
   localparam int MixShiftB = 6;
   localparam int FinShiftA = 3;
   localparam int FinShiftB = 11;
   localparam int FinShiftC = 15;

   typedef enum logic [KindBits-1:0] {
      KIND_ADD    = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_UPDATE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic take_item;   // item accepted this cycle
      logic fin_load;    // finalize hash, start slot reduction
      logic mem_read;    // read the slot entry
      logic exec;        // run the command, load the result register
      logic sweep_step;  // clear one slot entry
   } cmd_type;

   typedef struct packed {
      logic mod_busy;    // slot reduction still running
      logic sweep_last;  // sweep is at the final slot
      logic cmd_clear;   // latched command is clear table
   } status_type;

endpackage

// File: sv/hlst_ctrl.sv
// ----------------------------------------------------------------------------
// hlst_ctrl: command sequencer
// Walks each last item through finalize, reduce, read and execute, and runs
// the slot clearing sweep after reset and after a clear command.
// ----------------------------------------------------------------------------
module hlst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hlst_pkg::status_type status,
   output hlst_pkg::cmd_type   cmd
);
   import hlst_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FINISH,
      ST_DIVIDE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.take_item  = req_tvalid && (state_ff == ST_IDLE);
      cmd.fin_load   = (state_ff == ST_FINISH);
      cmd.mem_read   = (state_ff == ST_DIVIDE) && !status.mod_busy;
      cmd.exec       = (state_ff == ST_EXEC) && out_free;
      cmd.sweep_step = (state_ff == ST_SWEEP);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tlast) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.mod_busy) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = status.cmd_clear ? ST_SWEEP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/hlst_datapath.sv
// ----------------------------------------------------------------------------
// hlst_datapath: hash, slot reduction, slot memory and result register
// Accumulates the key hash, reduces the finalized hash to a slot index by a
// reciprocal multiplication (or by its low bits for a power-of-two slot
// count), and holds the occupied flag and value of each slot.
// ----------------------------------------------------------------------------
module hlst_datapath #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_LIMIT   = 60
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hlst_pkg::ReqDataBits-1:0]    req_tdata,
   input  logic                                req_tlast,
   input  logic [hlst_pkg::KindBits-1:0]       req_tuser,
   output logic [hlst_pkg::RspDataBits-1:0]    rsp_tdata,
   input  hlst_pkg::cmd_type                   cmd,
   output hlst_pkg::status_type                status
);
   import hlst_pkg::*;

   localparam int  SlotBits  = $clog2(TABLE_SLOTS);
   localparam int  OccBits   = $clog2(TABLE_SLOTS + 1);
   localparam int  ProdBits  = 2 * HashBits;
   localparam int  MemBits   = ValueBits + 1;
   localparam int  PadBits   = RspDataBits - ValueBits - 2;
   localparam bit  IsPow2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam logic [SlotBits:0]   SlotsWide = (SlotBits + 1)'(TABLE_SLOTS);
   localparam logic [SlotBits-1:0] LastSlot  = SlotBits'(TABLE_SLOTS - 1);
   localparam logic [CharsBits-1:0] KeyLimit = CharsBits'(KEY_LIMIT);
   // floor(2^32 / slots): the quotient estimate is low by at most one
   localparam logic [HashBits-1:0] Recip    =
      HashBits'((64'd1 << HashBits) / TABLE_SLOTS);
   localparam logic [HashBits-1:0] SlotsMul = HashBits'(TABLE_SLOTS);
   localparam logic [1:0]          ModSteps = IsPow2 ? 2'd0 : 2'd3;

   // key hash
   logic [HashBits-1:0]    hash_ff, hash_in;
   logic [CharsBits-1:0]   chars_ff, chars_in;
   logic                   stopped_ff, stopped_in;
   logic [KeyCharBits-1:0] key_char;
   logic [HashBits-1:0]    mix_a, mix_b, mix_c;
   logic [HashBits-1:0]    fin_a, fin_b, fin_c;

   // latched command
   kind_type               kind_ff;
   logic [ValueBits-1:0]   value_ff;

   // slot reduction
   logic [HashBits-1:0]    fin_ff;
   logic [ProdBits-1:0]    recip_prod;
   logic [HashBits-1:0]    quo_ff;
   logic [HashBits-1:0]    quo_mul;
   logic [HashBits-1:0]    part_full;
   logic [SlotBits:0]      part_ff;
   logic [SlotBits-1:0]    rem_ff;
   logic [1:0]             steps_ff;
   logic [SlotBits-1:0]    slot_idx;

   // slot memory
   logic [MemBits-1:0]     slot_mem [TABLE_SLOTS];
   logic [MemBits-1:0]     rd_ff;
   logic                   mem_we;
   logic [SlotBits-1:0]    mem_wa;
   logic [MemBits-1:0]     mem_wd;
   logic [SlotBits-1:0]    sweep_ff;
   logic                   occ;

   // occupancy count and result
   logic [OccBits-1:0]     count_ff, count_in;
   logic                   ok_in;
   logic [ValueBits-1:0]   rdval_in;
   logic                   ok_ff;
   logic [ValueBits-1:0]   rdval_ff;
   logic                   empty_ff;

   assign key_char = req_tdata[KeyCharBits-1:0];

   // one character of mixing
   always_comb begin
      mix_a = hash_ff + HashBits'(key_char);
      mix_b = mix_a + (mix_a << MixShiftA);
      mix_c = mix_b ^ (mix_b >> MixShiftB);
   end

   // finalization
   always_comb begin
      fin_a = hash_ff + (hash_ff << FinShiftA);
      fin_b = fin_a ^ (fin_a >> FinShiftB);
      fin_c = fin_b + (fin_b << FinShiftC);
   end

   always_comb begin
      hash_in    = hash_ff;
      chars_in   = chars_ff;
      stopped_in = stopped_ff;
      if (cmd.fin_load) begin
         hash_in    = '0;
         chars_in   = '0;
         stopped_in = 1'b0;
      end else if (cmd.take_item && !stopped_ff && (chars_ff < KeyLimit)) begin
         if (key_char == '0) begin
            stopped_in = 1'b1;
         end else begin
            hash_in  = mix_c;
            chars_in = chars_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff    <= '0;
         chars_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         hash_ff    <= hash_in;
         chars_ff   <= chars_in;
         stopped_ff <= stopped_in;
      end
   end

   // hold the command and value of the last item
   always_ff @(posedge clock) begin
      if (cmd.take_item && req_tlast) begin
         kind_ff  <= kind_type'(req_tuser);
         value_ff <= req_tdata[KeyCharBits +: ValueBits];
      end
   end

   // reduction: estimate the quotient, subtract its multiple, then one
   // compare and subtract brings the remainder below the slot count
   assign recip_prod = ProdBits'(fin_ff) * ProdBits'(Recip);
   assign quo_mul    = quo_ff * SlotsMul;
   assign part_full  = fin_ff - quo_mul;
   assign slot_idx   = IsPow2 ? fin_ff[SlotBits-1:0] : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.fin_load) fin_ff <= fin_c;
   end

   always_ff @(posedge clock) begin
      quo_ff  <= recip_prod[ProdBits-1:HashBits];
      part_ff <= part_full[SlotBits:0];
      rem_ff  <= (part_ff >= SlotsWide) ? SlotBits'(part_ff - SlotsWide)
                                        : part_ff[SlotBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (cmd.fin_load) begin
         steps_ff <= ModSteps;
      end else if (steps_ff != '0) begin
         steps_ff <= steps_ff - 1'b1;
      end
   end

   // slot memory: occupied flag on top of the stored value
   assign occ = rd_ff[MemBits-1];

   always_comb begin
      mem_we = cmd.sweep_step;
      mem_wa = sweep_ff;
      mem_wd = '0;
      if (!cmd.sweep_step && cmd.exec) begin
         mem_wa = slot_idx;
         mem_wd = {1'b1, value_ff};
         case (kind_ff)
            KIND_ADD:    mem_we = !occ;
            KIND_UPDATE: mem_we = occ;
            default:     mem_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_wa] <= mem_wd;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) rd_ff <= slot_mem[slot_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= (sweep_ff == LastSlot) ? '0 : sweep_ff + 1'b1;
      end
   end

   // command execution
   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      rdval_in = '0;
      case (kind_ff)
         KIND_ADD: begin
            if (!occ) begin
               ok_in    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_LOOKUP: begin
            if (occ) begin
               ok_in    = 1'b1;
               rdval_in = rd_ff[ValueBits-1:0];
            end
         end
         KIND_UPDATE: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in    = 1'b1;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         rdval_ff <= rdval_in;
         empty_ff <= (count_in == '0);
      end
   end

   assign rsp_tdata = {{PadBits{1'b0}}, empty_ff, rdval_ff, ok_ff};

   always_comb begin
      status.mod_busy   = (steps_ff != '0);
      status.sweep_last = (sweep_ff == LastSlot);
      status.cmd_clear  = (kind_ff == KIND_CLEAR);
   end

endmodule

// File: sv/hashed_label_slot_table_unit.sv
// ----------------------------------------------------------------------------
// hashed_label_slot_table_unit: direct-mapped value table keyed by a hash
// Each request item carries one key character; the item with req_tlast runs
// the command in req_tuser on the slot picked by the key's hash and returns
// one response item (success, value read, table empty).
//
// Channels: req_* takes key characters, rsp_* returns results. Items that are
// not last are taken one per cycle while no command or sweep is running and
// give no response. For the last item of a key, the 32-bit hash is reduced
// modulo the slot count by a reciprocal multiply, or by taking its low bits
// when TABLE_SLOTS is a power of two; the slot is then read and the command
// executed into the response. A clear command adds a sweep over every slot
// of the slot memory after its response, during which req_tready stays low.
// Reset: synchronous; the same sweep over every slot runs after reset
// before the first item is taken.
// Stall: a response held by rsp_tready low keeps its item; key characters
// keep flowing, and the next command waits until the result register frees.
// ----------------------------------------------------------------------------
module hashed_label_slot_table_unit #(
   parameter int TABLE_SLOTS = 256,
   parameter int KEY_LIMIT   = 60
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = key_char[6:0], new_value[22:7]; tuser = kind[1:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hlst_pkg::ReqDataBits-1:0] req_tdata,
   input  logic                             req_tlast,
   input  logic [hlst_pkg::KindBits-1:0]    req_tuser,
   // response: tdata = success[0], read_value[16:1], table_empty[17]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hlst_pkg::RspDataBits-1:0] rsp_tdata
);
   import hlst_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: accept, finalize, reduce, read, execute, sweep
   hlst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hash, reduction, slot memory, result register
   hlst_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_LIMIT   (KEY_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: tb/sv/hashed_label_slot_table_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_label_slot_table_unit_test: self-checking bench for the slot table
// Streams key characters into the request channel and keeps its own model of
// the one-at-a-time hash and the slot table. Every response item is compared
// field by field with the oldest predicted result. Directed keys come first,
// then long keys around the key limit, then a long random mix; every phase
// runs with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module hashed_label_slot_table_unit_test;
   import hlst_pkg::*;

   localparam int TableSlots  = 256;
   localparam int KeyLimit    = 60;
   localparam int ItemTarget  = 1350;
   localparam int PoolKeys    = 16;
   // response latency plus one full clear sweep, with margin
   localparam int SettleCycles = 400;

   typedef struct packed {
      logic          ok;
      logic [15:0]   value;
      logic          empty;
   } table_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;    // key_char[6:0], new_value[22:7]
   logic                   req_tlast = 1'b0;
   logic [KindBits-1:0]    req_tuser = KIND_ADD;  // kind[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;       // success[0], read_value[16:1], table_empty[17]

   // model of the hash front end
   logic [31:0]   key_hash = '0;
   int            key_len = 0;
   bit            key_ended = 1'b0;
   // model of the slot table
   bit            slot_full [TableSlots];
   logic [15:0]   slot_data [TableSlots];
   int            full_count = 0;

   table_result_type pending_results [$];

   // run bookkeeping
   int   error_count = 0;
   int   chars_sent = 0;
   int   commands_checked = 0;
   int   lookup_hits = 0;
   int   clears_sent = 0;
   bit   sender_burst = 1'b0;
   bit   receiver_burst = 1'b0;

   logic [6:0] key_pool [PoolKeys][$];
   logic [6:0] key_buf [$];

   hashed_label_slot_table_unit #(
      .TABLE_SLOTS (TableSlots),
      .KEY_LIMIT   (KeyLimit)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int draw_idle(bit burst);
      return burst ? 0 : $urandom_range(0, 18);
   endfunction

   // Advance the hash model by one character and, on the last one, run the
   // command on the table model and queue the result it should produce.
   function automatic void predict_table_result(kind_type kind, logic [6:0] ch,
                                                logic last, logic [15:0] val);
      logic [31:0]      h;
      int               slot;
      table_result_type r;
      if (!key_ended && key_len < KeyLimit) begin
         if (ch == 7'd0) begin
            key_ended = 1'b1;
         end else begin
            h = key_hash + {25'd0, ch};
            h = h + (h << MixShiftA);
            h = h ^ (h >> MixShiftB);
            key_hash = h;
            key_len++;
         end
      end
      if (!last) return;

      h = key_hash;
      h = h + (h << FinShiftA);
      h = h ^ (h >> FinShiftB);
      h = h + (h << FinShiftC);
      slot = h % TableSlots;
      key_hash = '0;
      key_len = 0;
      key_ended = 1'b0;

      r = '0;
      case (kind)
         KIND_ADD: begin
            if (!slot_full[slot]) begin
               slot_full[slot] = 1'b1;
               slot_data[slot] = val;
               full_count++;
               r.ok = 1'b1;
            end
         end
         KIND_LOOKUP: begin
            if (slot_full[slot]) begin
               r.value = slot_data[slot];
               r.ok = 1'b1;
            end
         end
         KIND_UPDATE: begin
            if (slot_full[slot]) slot_data[slot] = val;
            r.ok = 1'b1;
         end
         default: begin
            foreach (slot_full[i]) slot_full[i] = 1'b0;
            full_count = 0;
            r.ok = 1'b1;
         end
      endcase
      r.empty = (full_count == 0);
      pending_results.push_back(r);
   endfunction

   // Send one item after a random gap. Returns at the rising edge that takes
   // it; tvalid stays high so back-to-back items need no extra assignment.
   task automatic send_item(kind_type kind, logic [6:0] ch, logic last,
                            logic [15:0] val);
      int gap;
      gap = draw_idle(sender_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, val, ch};
      req_tuser  <= kind;
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_table_result(kind, ch, last, val);
      chars_sent++;
      if (last && kind == KIND_CLEAR) clears_sent++;
   endtask

   // Send a whole key; kind and value on the earlier characters are noise
   // that the block must ignore.
   task automatic send_key(kind_type kind, logic [6:0] key [$], logic [15:0] val);
      for (int i = 0; i < key.size(); i++) begin
         if (i == key.size() - 1) begin
            send_item(kind, key[i], 1'b1, val);
         end else begin
            send_item(kind_type'($urandom_range(0, 3)), key[i], 1'b0,
                      16'($urandom));
         end
      end
   endtask

   // Hold the request side idle until every predicted result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic void make_key(ref logic [6:0] key [$], input int len,
                                    input bit with_zero);
      key.delete();
      for (int i = 0; i < len; i++) key.push_back(7'($urandom_range(1, 127)));
      if (with_zero) key[$urandom_range(0, len - 1)] = 7'd0;
   endfunction

   // Response side: stall a random number of cycles before each item, then
   // take it and check it against the oldest prediction.
   initial begin
      int               stall;
      table_result_type want;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 7) == 0) receiver_burst = ~receiver_burst;
         stall = draw_idle(receiver_burst);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         if (pending_results.size() == 0) begin
            $error("response item with no command pending: tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            commands_checked++;
            if (want.ok && want.value != 16'd0) lookup_hits++;
            if (rsp_tdata[0] !== want.ok) begin
               $error("success: expected %0d, got %0d", want.ok, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[16:1] !== want.value) begin
               $error("read_value: expected %h, got %h", want.value, rsp_tdata[16:1]);
               error_count++;
            end
            if (rsp_tdata[17] !== want.empty) begin
               $error("table_empty: expected %0d, got %0d", want.empty, rsp_tdata[17]);
               error_count++;
            end
            if (rsp_tdata[23:18] !== 6'd0) begin
               $error("tdata padding: expected 0, got %h", rsp_tdata[23:18]);
               error_count++;
            end
         end
      end
   end

   // Short keys on a fresh table: misses, hits, refused adds, updates of
   // present and absent slots, a zero inside a key and a clear.
   task automatic test_directed();
      send_key(KIND_LOOKUP, '{7'h00}, 16'hFFFF);            // empty key, empty table
      send_key(KIND_ADD,    '{7'h41}, 16'hFFFF);            // "A"
      send_key(KIND_ADD,    '{7'h41}, 16'h1234);            // slot already taken
      send_key(KIND_LOOKUP, '{7'h41}, 16'h0000);
      send_key(KIND_UPDATE, '{7'h41}, 16'h0000);
      send_key(KIND_LOOKUP, '{7'h41}, 16'hFFFF);
      send_key(KIND_UPDATE, '{7'h7F, 7'h7F}, 16'hAAAA);     // most likely an empty slot
      send_key(KIND_LOOKUP, '{7'h7F, 7'h7F}, 16'h0000);
      send_key(KIND_LOOKUP, '{7'h41, 7'h00, 7'h51}, 16'h0000);  // hashes as "A"
      send_key(KIND_ADD,    '{7'h00, 7'h2A}, 16'h5555);     // empty key again
      send_key(KIND_LOOKUP, '{7'h00}, 16'h0000);
      send_key(KIND_CLEAR,  '{7'h42}, 16'hFFFF);
      send_key(KIND_LOOKUP, '{7'h41}, 16'h0000);
   endtask

   // Keys at and beyond the character limit: trailing characters, zero or
   // not, must not change the slot.
   task automatic test_key_limit();
      logic [6:0] base [$];
      make_key(base, KeyLimit, 1'b0);
      send_key(KIND_ADD, base, 16'hBEEF);
      key_buf = base;
      repeat (3) key_buf.push_back(7'($urandom_range(1, 127)));
      send_key(KIND_LOOKUP, key_buf, 16'h0000);
      key_buf = base;
      key_buf.push_back(7'd0);
      key_buf.push_back(7'h55);
      send_key(KIND_UPDATE, key_buf, 16'h8001);
      make_key(key_buf, KeyLimit - 1, 1'b0);
      key_buf.push_back(7'h01);
      send_key(KIND_LOOKUP, key_buf, 16'h0000);
      send_key(KIND_LOOKUP, base, 16'h0000);
   endtask

   // Random commands, mostly on a small pool of keys so that adds collide
   // and lookups hit; fresh keys, zero characters, overlong keys and clears
   // mixed in. Pause once midway until the table side is fully drained.
   task automatic test_random();
      int         pick;
      int         len;
      kind_type   kind;
      bit         paused;
      paused = 1'b0;
      foreach (key_pool[i]) make_key(key_pool[i], $urandom_range(1, 8), 1'b0);
      while (chars_sent < ItemTarget) begin
         if ($urandom_range(0, 4) == 0) sender_burst = ~sender_burst;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            key_buf = key_pool[$urandom_range(0, PoolKeys - 1)];
         end else if (pick < 95) begin
            len = $urandom_range(1, 10);
            make_key(key_buf, len, $urandom_range(0, 9) == 0);
         end else begin
            len = $urandom_range(KeyLimit + 1, KeyLimit + 6);
            make_key(key_buf, len, $urandom_range(0, 1) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)       kind = KIND_CLEAR;
         else if (pick < 40) kind = KIND_ADD;
         else if (pick < 75) kind = KIND_LOOKUP;
         else                kind = KIND_UPDATE;
         send_key(kind, key_buf, 16'($urandom));
         if (!paused && chars_sent >= ItemTarget / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_key_limit();
      test_random();

      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("run covered %0d key characters and %0d commands checked", chars_sent,
               commands_checked);
      $display("lookup hits with nonzero value: %0d, table clears: %0d", lookup_hits,
               clears_sent);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         if (pending_results.size() != 0)
            $error("%0d predicted results never arrived", pending_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
